// File: sv/mexp_pkg.sv
package mexp_pkg;

	// data word width
	localparam int WORD_BITS = 32;
	// bit counter width inside the modular multiplier
	localparam int CNT_BITS = $clog2(WORD_BITS);
	// microprogram step counter width
	localparam int STEP_BITS = 4;

	// configuration register indexes
	localparam logic REG_MODULUS  = 1'b0;
	localparam logic REG_EXPONENT = 1'b1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [STEP_BITS-1:0] step_t;

	// multiplier operand A source
	typedef enum logic {
		OPA_PROD = 1'b0,
		OPA_SQ   = 1'b1
	} opa_t;

	// multiplier operand B source
	typedef enum logic {
		OPB_BASE = 1'b0,
		OPB_SQ   = 1'b1
	} opb_t;

	// destination of a finished product
	typedef enum logic {
		DST_SQ   = 1'b0,
		DST_PROD = 1'b1
	} dst_t;

	// result value driven at an emit step
	typedef enum logic [1:0] {
		RES_PROD = 2'd0,
		RES_ONE  = 2'd1,
		RES_ZERO = 2'd2
	} res_t;

	// jump condition
	typedef enum logic [2:0] {
		C_NEXT    = 3'd0,
		C_ALWAYS  = 3'd1,
		C_NSTART  = 3'd2,
		C_EXPZ    = 3'd3,
		C_MODZ    = 3'd4,
		C_BIT0CLR = 3'd5,
		C_REMNZ   = 3'd6
	} cond_t;

	// one control word
	typedef struct packed {
		logic    go;
		opa_t    opa;
		opb_t    opb;
		logic    hold_mul;
		dst_t    dst;
		logic    shift;
		logic    emit;
		res_t    res;
		cond_t   cond;
		step_t   target;
	} ucode_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic start;
		logic exp_zero;
		logic mod_zero;
		logic bit0;
		logic rem_zero;
		logic mul_done;
	} status_t;

	// program step addresses
	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_CHKE   = 4'd1;
	localparam step_t ST_CHKM   = 4'd2;
	localparam step_t ST_RED    = 4'd3;
	localparam step_t ST_REDW   = 4'd4;
	localparam step_t ST_BIT    = 4'd5;
	localparam step_t ST_MUL    = 4'd6;
	localparam step_t ST_MULW   = 4'd7;
	localparam step_t ST_SQR    = 4'd8;
	localparam step_t ST_SQRW   = 4'd9;
	localparam step_t ST_LOOP   = 4'd10;
	localparam step_t ST_OUTP   = 4'd11;
	localparam step_t ST_OUT1   = 4'd12;
	localparam step_t ST_OUT0   = 4'd13;

	// microprogram ROM
	function automatic ucode_t mexp_ucode(input step_t step);
		ucode_t w;
		w = '0;
		case (step)
			ST_IDLE: begin
				w.cond   = C_NSTART;
				w.target = ST_IDLE;
			end
			ST_CHKE: begin
				w.cond   = C_EXPZ;
				w.target = ST_OUT1;
			end
			ST_CHKM: begin
				w.cond   = C_MODZ;
				w.target = ST_OUT0;
			end
			// square <- (1 mod m) * base mod m, i.e. base mod m
			ST_RED: begin
				w.go  = 1'b1;
				w.opa = OPA_PROD;
				w.opb = OPB_BASE;
			end
			ST_REDW: begin
				w.hold_mul = 1'b1;
				w.dst      = DST_SQ;
			end
			ST_BIT: begin
				w.cond   = C_BIT0CLR;
				w.target = ST_SQR;
			end
			ST_MUL: begin
				w.go  = 1'b1;
				w.opa = OPA_PROD;
				w.opb = OPB_SQ;
			end
			ST_MULW: begin
				w.hold_mul = 1'b1;
				w.dst      = DST_PROD;
			end
			ST_SQR: begin
				w.go  = 1'b1;
				w.opa = OPA_SQ;
				w.opb = OPB_SQ;
			end
			ST_SQRW: begin
				w.hold_mul = 1'b1;
				w.dst      = DST_SQ;
				w.shift    = 1'b1;
			end
			ST_LOOP: begin
				w.cond   = C_REMNZ;
				w.target = ST_BIT;
			end
			ST_OUTP: begin
				w.emit   = 1'b1;
				w.res    = RES_PROD;
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
			ST_OUT1: begin
				w.emit   = 1'b1;
				w.res    = RES_ONE;
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
			ST_OUT0: begin
				w.emit   = 1'b1;
				w.res    = RES_ZERO;
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: sv/mexp_mulmod.sv
module mexp_mulmod import mexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  word_t a,
	input  word_t b,
	input  word_t m,
	output logic  busy,
	output logic  done,
	output word_t r
);

	logic                run_q;
	logic                phase_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	word_t               a_q;
	word_t               b_q;
	word_t               r_q;

	logic [WORD_BITS:0] sum;
	logic [WORD_BITS:0] red;
	word_t              addend;

	// one shared add-and-reduce: double in phase 0, add A in phase 1
	always_comb begin
		addend = phase_q ? a_q : r_q;
		sum    = {1'b0, r_q} + {1'b0, addend};
		red    = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q   <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_BITS'(WORD_BITS - 1);
			end else if (run_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
			end
		end
	end

	// datapath, multiplier bits taken MSB first
	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (run_q) begin
			if (!phase_q) begin
				r_q <= red[WORD_BITS-1:0];
			end else begin
				if (b_q[WORD_BITS-1])
					r_q <= red[WORD_BITS-1:0];
				b_q <= {b_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign r    = r_q;

endmodule

// File: sv/mexp_seq.sv
module mexp_seq import mexp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	output ucode_t  cw,
	output logic    busy
);

	step_t step_q;
	step_t step_nxt;
	logic  taken;

	assign cw   = mexp_ucode(step_q);
	assign busy = (step_q != ST_IDLE);

	// jump condition select
	always_comb begin
		case (cw.cond)
			C_NEXT:    taken = 1'b0;
			C_ALWAYS:  taken = 1'b1;
			C_NSTART:  taken = !st.start;
			C_EXPZ:    taken = st.exp_zero;
			C_MODZ:    taken = st.mod_zero;
			C_BIT0CLR: taken = !st.bit0;
			C_REMNZ:   taken = !st.rem_zero;
			default:   taken = 1'b0;
		endcase
	end

	// hold on a wait step until the multiplier reports done
	always_comb begin
		if (cw.hold_mul && !st.mul_done)
			step_nxt = step_q;
		else if (taken)
			step_nxt = cw.target;
		else
			step_nxt = step_q + STEP_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= ST_IDLE;
		else
			step_q <= step_nxt;
	end

endmodule

// File: sv/modular_exponentiation.sv
// An exponent of zero and a modulus of zero are answered directly, with no modular product.
// Each modular product is computed in the shared bit-serial multiplier, which takes one
// add-and-reduce step for the doubling and one for the conditional add of A per multiplier bit.
// One request at a time; busy drops as done rises, so the next request can be taken then.
// done is a one-cycle strobe, the receiver cannot stall.
// Reset clears the sequencer and sets modulus to 2 and exponent to 0.
module modular_exponentiation import mexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  word_t base_value,
	output logic  done,
	output word_t power_result,
	input  logic  cfg_we,
	input  logic  cfg_index,
	input  word_t cfg_wdata
);

	word_t   mod_q;
	word_t   exp_q;
	word_t   base_q;
	word_t   prod_q;
	word_t   sq_q;
	word_t   rem_q;
	word_t   result_q;
	logic    done_q;

	ucode_t  cw;
	status_t st;
	word_t   opa;
	word_t   opb;
	word_t   mul_r;
	logic    mul_busy;
	logic    mul_done;
	logic    accept;
	logic    wr;

	assign accept = start && !busy;
	assign wr     = cw.hold_mul && mul_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= WORD_BITS'(2);
			exp_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS:  mod_q <= cfg_wdata;
				REG_EXPONENT: exp_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// sequencer status
	always_comb begin
		st.start    = start;
		st.exp_zero = (exp_q == '0);
		st.mod_zero = (mod_q == '0);
		st.bit0     = rem_q[0];
		st.rem_zero = (rem_q == '0);
		st.mul_done = mul_done;
	end

	mexp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cw     (cw),
		.busy   (busy)
	);

	// operand selection
	assign opa = (cw.opa == OPA_SQ) ? sq_q : prod_q;
	assign opb = (cw.opb == OPB_SQ) ? sq_q : base_q;

	mexp_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cw.go),
		.a      (opa),
		.b      (opb),
		.m      (mod_q),
		.busy   (mul_busy),
		.done   (mul_done),
		.r      (mul_r)
	);

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base_value;
			rem_q  <= exp_q;
			prod_q <= (mod_q == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
		end else if (wr) begin
			case (cw.dst)
				DST_SQ:   sq_q   <= mul_r;
				DST_PROD: prod_q <= mul_r;
				default:  ;
			endcase
			if (cw.shift)
				rem_q <= rem_q >> 1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cw.emit) begin
			case (cw.res)
				RES_PROD: result_q <= prod_q;
				RES_ONE:  result_q <= WORD_BITS'(1);
				RES_ZERO: result_q <= '0;
				default:  result_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cw.emit;
	end

	assign done         = done_q;
	assign power_result = result_q;

	// an accepted request leaves the idle step
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("sequencer did not leave idle on request");

	// the multiplier is never restarted while running
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cw.go |-> !mul_busy)
		else $error("multiplier started while busy");

	// a finished product only arrives on a wait step
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> cw.hold_mul)
		else $error("multiplier result arrived outside a wait step");

	// done is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

endmodule
